@@ sv/h2cv_pkg.sv @@
`timescale 1ns / 1ps

package h2cv_pkg;

  // Angle is a full-turn fraction; a quarter turn is 2^14
  localparam int AngleW   = 16;
  localparam int QuadBits = 14;
  localparam int SampleW  = 16;
  localparam int CoefW    = 31;
  localparam int NumCoef  = 5;
  localparam int DimW     = 5;

  localparam logic [QuadBits:0] QUARTER = 15'd16384;

  // Odd sine polynomial, unsigned Q1.30, innermost term first
  localparam logic [CoefW-1:0] COEF [NumCoef] = '{
    31'd172272,      // x^9
    31'd5026995,     // x^7
    31'd85569306,    // x^5
    31'd693598668,   // x^3
    31'd1686629713   // x^1
  };

  // One trig pipeline stage: both quarter-wave lanes (r and quarter - r)
  typedef struct packed {
    logic [1:0]         quad;
    logic [15:0]        x_lo;
    logic [15:0]        x_hi;
    logic [15:0]        z_lo;
    logic [15:0]        z_hi;
    logic [CoefW-1:0]   t_lo;
    logic [CoefW-1:0]   t_hi;
  } trig_stage_t;

  // z = x*x >> 15
  function automatic logic [15:0] square_q15(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(x);
    return prod[30:15];
  endfunction

  // One Horner step: c - (z*t >> 15)
  function automatic logic [CoefW-1:0] horner_step(input logic [CoefW-1:0] c,
                                                   input logic [15:0] z,
                                                   input logic [CoefW-1:0] t);
    logic [46:0] prod;
    prod = 47'(z) * 47'(t);
    return c - prod[45:15];
  endfunction

  // Final term x*t, rounded half up by >> 30, magnitude capped at 32767
  function automatic logic [14:0] sine_round(input logic [15:0] x,
                                             input logic [CoefW-1:0] t);
    logic [46:0] prod;
    logic [16:0] s;
    prod = 47'(x) * 47'(t) + (47'(1) << 29);
    s    = prod[46:30];
    return (s > 17'd32767) ? 15'h7fff : s[14:0];
  endfunction

  // Q1.15 product: add half, floor shift, saturate
  function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic signed [31:0] prod;
    logic signed [32:0] sum;
    logic signed [17:0] q;
    prod = a * b;
    sum  = 33'(prod) + 33'sd16384;
    q    = 18'(sum >>> 15);
    if (q > 18'sd32767) begin
      return 16'sh7fff;
    end else if (q < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

endpackage

@@ sv/hyperspherical_to_complex_vector.sv @@
`timescale 1ns / 1ps
// Throughput: one angle per cycle unless out_stall backs up the full pipeline;
// the sine/cosine polynomial runs in six pipeline stages and the sine-product
// recurrence closes in the output stage.
// Reset (rst_n low, synchronous): pipeline empty, position and products zero,
// dimension register back to 2.
module hyperspherical_to_complex_vector #(
  parameter int MAX_COMPONENTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [h2cv_pkg::DimW-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [h2cv_pkg::AngleW-1:0]       in_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_real_part,
  output logic signed [15:0]                out_imag_part,
  output logic [3:0]                        out_component_index,
  output logic                              out_last_component
);
  import h2cv_pkg::*;

  localparam int PW = $clog2(2 * MAX_COMPONENTS);
  localparam int CW = (PW > DimW) ? PW + 1 : DimW + 1;
  localparam int NS = 7;   // trig stages 0..5 plus sin/cos stage 6

  // ---------------------------------------------------------------
  // Configuration
  logic [DimW-1:0] dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DimW'(2);
    end else if (cfg_wr_en) begin
      dim_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or draining
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic          out_valid_r;

  always_comb begin
    rdy[NS] = !out_valid_r || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Trig stages: split angle, square, then Horner steps
  trig_stage_t st_r   [6];
  trig_stage_t st_nxt [6];
  logic [QuadBits-1:0] rem;

  assign rem = in_angle[QuadBits-1:0];

  always_comb begin
    st_nxt[0]      = st_r[0];
    st_nxt[0].quad = in_angle[AngleW-1:QuadBits];
    st_nxt[0].x_lo = {1'b0, rem, 1'b0};
    st_nxt[0].x_hi = {QUARTER - {1'b0, rem}, 1'b0};

    st_nxt[1]      = st_r[0];
    st_nxt[1].z_lo = square_q15(st_r[0].x_lo);
    st_nxt[1].z_hi = square_q15(st_r[0].x_hi);
    st_nxt[1].t_lo = COEF[0];
    st_nxt[1].t_hi = COEF[0];

    for (int k = 2; k < 6; k++) begin
      st_nxt[k]      = st_r[k-1];
      st_nxt[k].t_lo = horner_step(COEF[k-1], st_r[k-1].z_lo, st_r[k-1].t_lo);
      st_nxt[k].t_hi = horner_step(COEF[k-1], st_r[k-1].z_hi, st_r[k-1].t_hi);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------
  // Sine/cosine: final rounding, quadrant mirror and sign
  logic [14:0]        mag_lo, mag_hi, sin_mag, cos_mag;
  logic [1:0]         quad;
  logic signed [15:0] sin_nxt, cos_nxt;
  logic signed [15:0] sin_r, cos_r;

  always_comb begin
    quad    = st_r[5].quad;
    mag_lo  = sine_round(st_r[5].x_lo, st_r[5].t_lo);
    mag_hi  = sine_round(st_r[5].x_hi, st_r[5].t_hi);
    sin_mag = quad[0] ? mag_hi : mag_lo;
    cos_mag = quad[0] ? mag_lo : mag_hi;
    sin_nxt = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    cos_nxt = (quad[1] ^ quad[0]) ? -$signed({1'b0, cos_mag})
                                  : $signed({1'b0, cos_mag});
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Component recurrence and output register
  logic [PW-1:0]      pos_r, pos_nxt;
  logic signed [15:0] sprod_r, sprod_nxt;
  logic signed [15:0] held_r, held_nxt;
  logic               out_valid_nxt;
  logic signed [15:0] out_real_r, out_real_nxt;
  logic signed [15:0] out_imag_r, out_imag_nxt;
  logic [3:0]         out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CW-1:0]      dim_ext, d_eff, fin, pos_ext;
  logic               take, at_last;
  logic signed [15:0] m_cos, m_sin;

  assign take = v_r[6] && rdy[NS];

  always_comb begin
    // clamp dimension into its legal range
    dim_ext = CW'(dim_r);
    if (dim_ext < CW'(2)) begin
      d_eff = CW'(2);
    end else if (dim_ext > CW'(MAX_COMPONENTS)) begin
      d_eff = CW'(MAX_COMPONENTS);
    end else begin
      d_eff = dim_ext;
    end
    fin     = (d_eff << 1) - CW'(3);
    pos_ext = CW'(pos_r);
    at_last = pos_ext >= fin;

    m_cos = qmul(sprod_r, cos_r);
    m_sin = qmul(sprod_r, sin_r);

    pos_nxt       = pos_r;
    sprod_nxt     = sprod_r;
    held_nxt      = held_r;
    out_valid_nxt = rdy[NS] ? 1'b0 : out_valid_r;
    out_real_nxt  = out_real_r;
    out_imag_nxt  = out_imag_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    if (take) begin
      priority if (at_last) begin
        // final angle closes the vector
        out_valid_nxt = 1'b1;
        out_real_nxt  = m_cos;
        out_imag_nxt  = m_sin;
        out_idx_nxt   = 4'(d_eff - CW'(1));
        out_last_nxt  = 1'b1;
        pos_nxt       = '0;
      end else if (pos_r == '0) begin
        // first component is purely real
        out_valid_nxt = 1'b1;
        out_real_nxt  = cos_r;
        out_imag_nxt  = '0;
        out_idx_nxt   = '0;
        out_last_nxt  = 1'b0;
        sprod_nxt     = sin_r;
        pos_nxt       = PW'(1);
      end else if (pos_r[0]) begin
        // odd angle: hold the real part, no result
        held_nxt  = m_cos;
        sprod_nxt = m_sin;
        pos_nxt   = pos_r + PW'(1);
      end else begin
        // even angle: emit held real with new imaginary part
        out_valid_nxt = 1'b1;
        out_real_nxt  = held_r;
        out_imag_nxt  = m_cos;
        out_idx_nxt   = 4'(pos_ext >> 1);
        out_last_nxt  = 1'b0;
        sprod_nxt     = m_sin;
        pos_nxt       = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sprod_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sprod_r     <= sprod_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_real_r <= out_real_nxt;
    out_imag_r <= out_imag_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_real_part       = out_real_r;
  assign out_imag_part       = out_imag_r;
  assign out_component_index = out_idx_r;
  assign out_last_component  = out_last_r;

  // ---------------------------------------------------------------
  // Assertions

  // input stalls only when the whole pipe is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // final angle restarts the position
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && at_last) |=> (pos_r == '0))
    else $error("position did not restart after final angle");

  // an odd angle produces no result
  a_odd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !at_last && pos_r[0]) |=> !out_valid_r)
    else $error("result emitted for an odd angle");

  // first component carries a zero imaginary part
  a_first_real: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r && out_idx_r == '0) |-> (out_imag_r == '0))
    else $error("component zero has a nonzero imaginary part");

endmodule

@@ tb/hyperspherical_to_complex_vector_tb.sv @@
`timescale 1ns / 1ps

module hyperspherical_to_complex_vector_tb;

  localparam int MAX_COMPONENTS  = 16;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 12;    // margin for the pipeline to drain
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TARGET_ITEMS    = 720;
  localparam int NUM_DIRECTED    = 8;

  // Gap styles of the request sender
  localparam int GAPS_NONE   = 0;
  localparam int GAPS_MIXED  = 1;
  localparam int GAPS_SPARSE = 2;

  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
    logic [3:0]         index;
    logic               last;
  } component_t;

  // Tracks angle position and sine product, queues expected components
  class component_scoreboard;
    localparam longint unsigned SIN_C1 = 64'd1686629713;
    localparam longint unsigned SIN_C3 = 64'd693598668;
    localparam longint unsigned SIN_C5 = 64'd85569306;
    localparam longint unsigned SIN_C7 = 64'd5026995;
    localparam longint unsigned SIN_C9 = 64'd172272;

    logic [4:0]         dimension;
    int unsigned        position;
    logic signed [15:0] sine_prod;
    logic signed [15:0] held_re;
    component_t         expected_q[$];
    int                 failures;

    function void reset_state();
      dimension = 5'd2;
      position  = 0;
      sine_prod = '0;
      held_re   = '0;
      expected_q.delete();
      failures  = 0;
    endfunction

    function void set_dimension(logic [4:0] d);
      dimension = d;
    endfunction

    // Register value clamped to the supported range
    function int unsigned effective_dimension(logic [4:0] d);
      if (d < 2) return 2;
      if (d > MAX_COMPONENTS) return MAX_COMPONENTS;
      return d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Odd polynomial over one quarter wave, r in 0..16384
    function int quarter_wave_sine(int unsigned r);
      longint unsigned x, z, t, s;
      x = 64'(r) << 1;
      z = (x * x) >> 15;
      t = SIN_C9;
      t = SIN_C7 - ((z * t) >> 15);
      t = SIN_C5 - ((z * t) >> 15);
      t = SIN_C3 - ((z * t) >> 15);
      t = SIN_C1 - ((z * t) >> 15);
      s = (x * t + (64'd1 << 29)) >> 30;
      if (s > 64'd32767) s = 64'd32767;
      return int'(s);
    endfunction

    function logic signed [15:0] sine_q15(logic [15:0] a);
      int m;
      int v;
      m = a[14] ? quarter_wave_sine(16384 - a[13:0]) : quarter_wave_sine(a[13:0]);
      v = a[15] ? -m : m;
      return v[15:0];
    endfunction

    function logic signed [15:0] cosine_q15(logic [15:0] a);
      logic [15:0] shifted;
      shifted = a + 16'd16384;
      return sine_q15(shifted);
    endfunction

    // Q1.15 product, half added, floor shift, saturated
    function logic signed [15:0] scale_q15(logic signed [15:0] a, logic signed [15:0] b);
      int p, q;
      p = int'(a) * int'(b) + 16384;
      q = p >>> 15;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_angle(logic [15:0] a);
      int unsigned        d;
      int unsigned        fin;
      logic signed [15:0] s, c;
      component_t         comp;
      d   = effective_dimension(dimension);
      fin = 2 * d - 3;
      s   = sine_q15(a);
      c   = cosine_q15(a);
      if (position >= fin) begin
        // final angle, also taken when a smaller dimension arrived mid-vector
        comp.real_part = scale_q15(sine_prod, c);
        comp.imag_part = scale_q15(sine_prod, s);
        comp.index     = 4'(d - 1);
        comp.last      = 1'b1;
        expected_q.push_back(comp);
        position = 0;
      end else if (position == 0) begin
        comp.real_part = c;
        comp.imag_part = '0;
        comp.index     = '0;
        comp.last      = 1'b0;
        expected_q.push_back(comp);
        sine_prod = s;
        position  = 1;
      end else if (position[0]) begin
        // odd angle: hold real part, no output
        held_re   = scale_q15(sine_prod, c);
        sine_prod = scale_q15(sine_prod, s);
        position  = position + 1;
      end else begin
        comp.real_part = held_re;
        comp.imag_part = scale_q15(sine_prod, c);
        comp.index     = 4'(position >> 1);
        comp.last      = 1'b0;
        expected_q.push_back(comp);
        sine_prod = scale_q15(sine_prod, s);
        position  = position + 1;
      end
    endfunction

    function void check_component(component_t got);
      component_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected component: re=%0d im=%0d idx=%0d last=%0b",
                   got.real_part, got.imag_part, got.index, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.real_part !== want.real_part || got.imag_part !== want.imag_part ||
          got.index !== want.index || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("component mismatch: exp re=%0d im=%0d idx=%0d last=%0b, got re=%0d im=%0d idx=%0d last=%0b",
                   want.real_part, want.imag_part, want.index, want.last,
                   got.real_part, got.imag_part, got.index, got.last);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [h2cv_pkg::DimW-1:0] cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [h2cv_pkg::AngleW-1:0] in_angle;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [15:0]        out_real_part;
  logic signed [15:0]        out_imag_part;
  logic [3:0]                out_component_index;
  logic                      out_last_component;

  component_scoreboard sb = new();
  int sent_count        = 0;
  int hold_off_requests = 0;
  bit sink_calm         = 1'b0;

  hyperspherical_to_complex_vector #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_angle           (in_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_real_part      (out_real_part),
    .out_imag_part      (out_imag_part),
    .out_component_index(out_component_index),
    .out_last_component (out_last_component)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int next_gap(int style);
    if (style == GAPS_NONE) return 0;
    if (style == GAPS_SPARSE) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Mostly uniform angles, some right at quadrant boundaries
  function automatic logic [15:0] next_angle();
    logic [15:0] base;
    if ($urandom_range(0, 7) != 0) return 16'($urandom());
    base = 16'($urandom_range(0, 3) << 14);
    return base + 16'($urandom_range(0, 2)) - 16'd1;
  endfunction

  // One angle request; returns at the edge where it is accepted
  task automatic offer_angle(input logic [15:0] a, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_angle(a);
    sent_count++;
  endtask

  // Odd angles give no output, so let the pipeline run empty
  task automatic let_pipeline_settle();
    int settled;
    settled = 0;
    while (sb.pending() != 0) @(posedge clk);
    while (settled < SETTLE_CYCLES) begin
      @(posedge clk);
      if (!out_stall) settled++;
    end
  endtask

  task automatic program_dimension(input logic [4:0] d);
    let_pipeline_settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    sb.set_dimension(d);
    cfg_wr_en <= 1'b0;
  endtask

  // Result sink: checks components, stalls at random, long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_offs_seen;
    component_t got;
    stall_left     = 0;
    hold_offs_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.real_part = out_real_part;
        got.imag_part = out_imag_part;
        got.index     = out_component_index;
        got.last      = out_last_component;
        sb.check_component(got);
      end
      if (hold_off_requests != hold_offs_seen) begin
        hold_offs_seen = hold_off_requests;
        stall_left     = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted request or delivered component
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("hyperspherical_to_complex_vector: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] dim2_angles [NUM_DIRECTED];
    logic [15:0] dim3_angles [NUM_DIRECTED];
    logic [4:0]  dim;
    int          per_vec;
    int          n_items;
    int          gap_style;
    int          phase;
    bit          pressure;

    dim2_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                    16'hFFFF, 16'h3FFF, 16'h0001, 16'h7FFF};
    dim3_angles = '{16'h2000, 16'h6000, 16'hA000, 16'hE000,
                    16'hFFFF, 16'h4000, 16'h0000, 16'hC001};

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_angle    <= '0;
    sb.reset_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset dimension of 2, quadrant edges and extremes
    for (int i = 0; i < NUM_DIRECTED; i++) offer_angle(dim2_angles[i], next_gap(GAPS_MIXED));
    in_valid <= 1'b0;

    program_dimension(5'd3);
    for (int i = 0; i < NUM_DIRECTED; i++) offer_angle(dim3_angles[i], next_gap(GAPS_MIXED));
    // stop after an odd angle, then shrink the dimension mid-vector
    offer_angle(16'h1000, 0);
    offer_angle(16'h5000, 0);
    in_valid <= 1'b0;
    program_dimension(5'd2);
    offer_angle(16'h9000, 0);
    in_valid <= 1'b0;

    // dimension below range acts as 2
    program_dimension(5'd0);
    offer_angle(16'h1234, 0);
    offer_angle(16'hBEEF, 0);
    in_valid <= 1'b0;

    // Random phases: mostly whole vectors, some cut short mid-vector
    phase = 0;
    while (sent_count < TARGET_ITEMS) begin
      pressure = (phase == 2);
      if (pressure) begin
        dim = 5'd16;
      end else begin
        case ($urandom_range(0, 7))
          0:       dim = 5'd2;
          1:       dim = 5'd16;
          2:       dim = 5'($urandom_range(0, 1));
          3:       dim = 5'($urandom_range(17, 31));
          default: dim = 5'($urandom_range(2, 16));
        endcase
      end
      program_dimension(dim);
      per_vec = 2 * sb.effective_dimension(dim) - 2;
      if (pressure) begin
        n_items   = 3 * per_vec;
        gap_style = GAPS_NONE;
        hold_off_requests <= hold_off_requests + 1;
      end else begin
        n_items = $urandom_range(1, 4) * per_vec;
        if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, per_vec - 1);
        gap_style = $urandom_range(GAPS_NONE, GAPS_SPARSE);
      end
      sink_calm <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_items; k++) offer_angle(next_angle(), next_gap(gap_style));
      in_valid <= 1'b0;
      phase++;
    end

    let_pipeline_settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("hyperspherical_to_complex_vector: match");
    end else begin
      $display("hyperspherical_to_complex_vector: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/h2cv_pkg.sv
sv/hyperspherical_to_complex_vector.sv
tb/hyperspherical_to_complex_vector_tb.sv
